// ===== sv/ssd_pkg.sv =====
`default_nettype none

package ssd_pkg;

    localparam int DEFAULT_MAX_DIGITS = 8;

    localparam int CNT_W    = 4;
    localparam int FRAME_W  = 16;
    localparam int NOW_W    = 32;
    localparam int DIGIT_W  = 3;
    localparam int SEG_W    = 8;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [CNT_W-1:0]   RESET_DIGIT_COUNT = 4'd4;
    localparam logic [FRAME_W-1:0] RESET_FRAME_TIME  = 16'd16;
    localparam logic [FRAME_W-1:0] RESET_PERIOD      = 16'd4;

    localparam logic [SEG_W-1:0] SEG_MASK     = 8'h7F;
    localparam logic [SEG_W-1:0] DOT_BIT      = 8'h80;
    localparam logic [SEG_W-1:0] BLANK_ANODE  = 8'hFF;
    localparam logic [SEG_W-1:0] BLANK_CATH   = 8'h00;

    localparam logic [1:0] FUNC_TIME  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] KIND_LINE   = 2'd0;
    localparam logic [1:0] KIND_SEG    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [1:0] REG_DIGIT_COUNT  = 2'd0;
    localparam logic [1:0] REG_COMMON_ANODE = 2'd1;
    localparam logic [1:0] REG_FRAME_TIME   = 2'd2;

    localparam int CMD_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_TIME,
        OP_WRITE,
        OP_WRITE_BAD,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [NOW_W-1:0]   now_ms;
        logic [DIGIT_W-1:0] digit_index;
        logic [SEG_W-1:0]   pattern;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]   digit_count;
        logic               common_anode;
        logic [FRAME_W-1:0] period;
        logic               period_busy;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         kind;
        logic [DIGIT_W-1:0] line_digit;
        logic               line_level;
        logic [SEG_W-1:0]   segment_bits;
        logic               status;
        logic               last;
    } t_res;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_TIME_OFF,
        BS_TIME_SEG,
        BS_TIME_ON,
        BS_CLR_OFF,
        BS_CLR_SEG
    } t_bstate;

endpackage

`default_nettype wire

// ===== sv/ssd_cfg.sv =====
`default_nettype none

module ssd_cfg
    import ssd_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg,
    output logic                   o_count_written
);

    localparam int STEP_W = $clog2(FRAME_W);

    logic [CNT_W-1:0]   r_digit_count, n_digit_count;
    logic               r_common_anode, n_common_anode;
    logic [FRAME_W-1:0] r_frame_time, n_frame_time;
    logic [FRAME_W-1:0] r_period, n_period;
    logic               r_busy, n_busy;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [FRAME_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0]   r_dvs, n_dvs;

    logic             wr_en;
    logic [CNT_W-1:0] count_in;
    logic [CNT_W:0]   trial;
    logic             q_bit;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        count_in = pwdata[CNT_W-1:0];
        if (count_in == '0) begin
            count_in = CNT_W'(1);
        end else if ((CNT_W+1)'(count_in) > (CNT_W+1)'(MAX_DIGITS)) begin
            count_in = CNT_W'(MAX_DIGITS);
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DIGIT_COUNT:  prdata = APB_DW'(r_digit_count);
            REG_COMMON_ANODE: prdata = APB_DW'(r_common_anode);
            REG_FRAME_TIME:   prdata = APB_DW'(r_frame_time);
            default:          prdata = '0;
        endcase
    end

    // Restoring division of the frame time by the digit count, one quotient
    // bit per cycle.
    always_comb begin
        n_digit_count  = r_digit_count;
        n_common_anode = r_common_anode;
        n_frame_time   = r_frame_time;
        n_period       = r_period;
        n_busy         = r_busy;
        n_step         = r_step;
        n_rem          = r_rem;
        n_quo          = r_quo;
        n_dvs          = r_dvs;
        o_count_written = 1'b0;

        trial = {r_rem, r_quo[FRAME_W-1]};
        q_bit = (trial >= {1'b0, r_dvs});

        if (r_busy) begin
            n_rem  = q_bit ? CNT_W'(trial - {1'b0, r_dvs}) : trial[CNT_W-1:0];
            n_quo  = {r_quo[FRAME_W-2:0], q_bit};
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(FRAME_W - 1)) begin
                n_busy   = 1'b0;
                n_period = (n_quo == '0) ? FRAME_W'(1) : n_quo;
            end
        end

        if (wr_en) begin
            unique case (paddr[3:2])
                REG_DIGIT_COUNT: begin
                    n_digit_count   = count_in;
                    o_count_written = 1'b1;
                end
                REG_COMMON_ANODE: n_common_anode = pwdata[0];
                REG_FRAME_TIME:   n_frame_time   = pwdata[FRAME_W-1:0];
                default: ;
            endcase
            if (paddr[3:2] == REG_DIGIT_COUNT || paddr[3:2] == REG_FRAME_TIME) begin
                n_busy = 1'b1;
                n_step = '0;
                n_rem  = '0;
                n_quo  = n_frame_time;
                n_dvs  = n_digit_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count  <= RESET_DIGIT_COUNT;
            r_common_anode <= 1'b0;
            r_frame_time   <= RESET_FRAME_TIME;
            r_period       <= RESET_PERIOD;
            r_busy         <= 1'b0;
            r_step         <= '0;
        end else begin
            r_digit_count  <= n_digit_count;
            r_common_anode <= n_common_anode;
            r_frame_time   <= n_frame_time;
            r_period       <= n_period;
            r_busy         <= n_busy;
            r_step         <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_cfg.digit_count  = r_digit_count;
    assign o_cfg.common_anode = r_common_anode;
    assign o_cfg.period       = r_period;
    assign o_cfg.period_busy  = r_busy;

endmodule

`default_nettype wire

// ===== sv/ssd_front.sv =====
`default_nettype none

module ssd_front
    import ssd_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  wire logic               i_push,
    input  wire logic [1:0]         i_func,
    input  wire logic [NOW_W-1:0]   i_now_ms,
    input  wire logic [DIGIT_W-1:0] i_digit_index,
    input  wire logic [SEG_W-1:0]   i_segments,
    input  wire logic               i_dot,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_q_full,
    output logic                    o_full,
    output logic                    o_q_push,
    output t_cmd                    o_cmd
);

    localparam int CMP_W = (DIGIT_W > CNT_W ? DIGIT_W : CNT_W) + 2;

    logic out_of_range;

    assign o_full = i_q_full;

    assign out_of_range = (CMP_W'(i_digit_index) >= CMP_W'(i_cfg.digit_count)) ||
                          (CMP_W'(i_digit_index) >= CMP_W'(MAX_DIGITS));

    always_comb begin
        o_cmd.now_ms      = i_now_ms;
        o_cmd.digit_index = i_digit_index;
        o_cmd.pattern     = (i_segments & SEG_MASK) | (i_dot ? DOT_BIT : '0);
        o_cmd.op          = OP_TIME;
        o_q_push          = 1'b0;
        // An unknown function code is taken and dropped here.
        unique case (i_func)
            FUNC_TIME: begin
                o_cmd.op = OP_TIME;
                o_q_push = i_push && !i_q_full;
            end
            FUNC_WRITE: begin
                o_cmd.op = out_of_range ? OP_WRITE_BAD : OP_WRITE;
                o_q_push = i_push && !i_q_full;
            end
            FUNC_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                o_q_push = i_push && !i_q_full;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/ssd_fifo.sv =====
`default_nettype none

module ssd_fifo
    import ssd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_data
);

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_QW = $clog2(CMD_DEPTH + 1);

    t_cmd              r_mem [CMD_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_QW-1:0] r_cnt, n_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == CNT_QW'(CMD_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_QW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_QW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ssd_back.sv =====
`default_nettype none

module ssd_back
    import ssd_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_count_written,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_res      o_res
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CMP_W = (IDX_W > CNT_W ? IDX_W : CNT_W) + 1;

    t_bstate          r_state, n_state;
    logic [SEG_W-1:0] r_store [MAX_DIGITS];
    logic [SEG_W-1:0] n_store [MAX_DIGITS];
    logic [IDX_W-1:0] r_scan, n_scan;
    logic [NOW_W-1:0] r_last_ms, n_last_ms;
    logic [IDX_W-1:0] r_d, n_d;
    logic [CNT_W-1:0] r_i, n_i;
    logic             r_valid, n_valid;
    t_res             r_res, n_res;

    logic             out_free;
    logic             emit;
    t_res             res;
    logic [NOW_W-1:0] elapsed;
    logic [IDX_W-1:0] d_cur;
    logic [CMP_W-1:0] d_inc;
    logic             off_level;
    logic [SEG_W-1:0] seg_now;

    assign out_free  = !r_valid || i_pop;
    assign off_level = !i_cfg.common_anode;
    assign elapsed   = i_cmd.now_ms - r_last_ms;
    assign d_cur     = (CMP_W'(r_scan) >= CMP_W'(i_cfg.digit_count)) ? '0 : r_scan;
    assign d_inc     = CMP_W'(d_cur) + CMP_W'(1);
    assign seg_now   = i_cfg.common_anode ? ~r_store[r_d] : r_store[r_d];

    always_comb begin
        n_state   = r_state;
        n_store   = r_store;
        n_scan    = r_scan;
        n_last_ms = r_last_ms;
        n_d       = r_d;
        n_i       = r_i;
        o_cmd_pop = 1'b0;
        emit      = 1'b0;
        res       = '0;

        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_TIME: begin
                            if (!i_cfg.period_busy) begin
                                o_cmd_pop = 1'b1;
                                if (elapsed >= NOW_W'(i_cfg.period)) begin
                                    n_d       = d_cur;
                                    n_scan    = (d_inc == CMP_W'(i_cfg.digit_count)) ?
                                                '0 : IDX_W'(d_inc);
                                    n_last_ms = i_cmd.now_ms;
                                    n_state   = BS_TIME_OFF;
                                end
                            end
                        end
                        OP_WRITE: begin
                            if (out_free) begin
                                o_cmd_pop = 1'b1;
                                n_store[IDX_W'(i_cmd.digit_index)] = i_cmd.pattern;
                                emit        = 1'b1;
                                res.kind    = KIND_STATUS;
                                res.status  = STATUS_OK;
                                res.last    = 1'b1;
                            end
                        end
                        OP_WRITE_BAD: begin
                            if (out_free) begin
                                o_cmd_pop  = 1'b1;
                                emit       = 1'b1;
                                res.kind   = KIND_STATUS;
                                res.status = STATUS_RANGE;
                                res.last   = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd_pop = 1'b1;
                            for (int k = 0; k < MAX_DIGITS; k++) begin
                                n_store[k] = '0;
                            end
                            n_i     = '0;
                            n_state = BS_CLR_OFF;
                        end
                        default: ;
                    endcase
                end
            end
            BS_TIME_OFF: begin
                if (out_free) begin
                    emit           = 1'b1;
                    res.kind       = KIND_LINE;
                    res.line_digit = DIGIT_W'(r_d);
                    res.line_level = off_level;
                    n_state        = BS_TIME_SEG;
                end
            end
            BS_TIME_SEG: begin
                if (out_free) begin
                    emit             = 1'b1;
                    res.kind         = KIND_SEG;
                    res.segment_bits = seg_now;
                    n_state          = BS_TIME_ON;
                end
            end
            BS_TIME_ON: begin
                if (out_free) begin
                    emit           = 1'b1;
                    res.kind       = KIND_LINE;
                    res.line_digit = DIGIT_W'(r_d);
                    res.line_level = !off_level;
                    res.last       = 1'b1;
                    n_state        = BS_IDLE;
                end
            end
            BS_CLR_OFF: begin
                if (out_free) begin
                    emit           = 1'b1;
                    res.kind       = KIND_LINE;
                    res.line_digit = DIGIT_W'(r_i);
                    res.line_level = off_level;
                    n_i            = r_i + CNT_W'(1);
                    if ((CNT_W+1)'(r_i) + (CNT_W+1)'(1) == (CNT_W+1)'(i_cfg.digit_count)) begin
                        n_state = BS_CLR_SEG;
                    end
                end
            end
            BS_CLR_SEG: begin
                if (out_free) begin
                    emit             = 1'b1;
                    res.kind         = KIND_SEG;
                    res.segment_bits = i_cfg.common_anode ? BLANK_ANODE : BLANK_CATH;
                    res.last         = 1'b1;
                    n_state          = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase

        // A new digit count restarts the scan at the first digit.
        if (i_count_written) begin
            n_scan = '0;
        end

        n_res   = emit ? res : r_res;
        n_valid = emit ? 1'b1 : (i_pop ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_scan    <= '0;
            r_last_ms <= '0;
            r_valid   <= 1'b0;
            for (int k = 0; k < MAX_DIGITS; k++) begin
                r_store[k] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_scan    <= n_scan;
            r_last_ms <= n_last_ms;
            r_valid   <= n_valid;
            r_store   <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d   <= n_d;
        r_i   <= n_i;
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ===== sv/seven_segment_scan_driver.sv =====
// Multiplexed seven-segment display scan driver.
// Items go in through a queue-style port: an item transfers on a rising edge
// with i_push high and o_full low. Func selects a time update, a digit write
// or a clear; func 3 is taken and discarded. Results come out the same way:
// the oldest result sits on the o_ ports while o_empty is low and transfers
// on an edge with i_pop high. o_last marks the final result of each item.
// A front stage classifies items into a two-entry command queue; the back
// sequencer executes them and emits one result per cycle into an output
// register. A write at the queue head gives its status; a time step gives
// three results; a clear gives one line result per digit, then a blank
// segment result. The back stage stalls whenever the output register is
// still held, and the input side fills the queue until o_full rises.
// Writing digit_count or the frame time starts a serial division for the
// digit period; time items wait at the queue head until it completes.
// Synchronous reset blanks the pattern store, sets the registers to four
// digits, common cathode and a 16 ms frame, and empties both queues.
`default_nettype none

module seven_segment_scan_driver
    import ssd_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [1:0]         i_func,
    input  wire logic [NOW_W-1:0]   i_now_ms,
    input  wire logic [DIGIT_W-1:0] i_digit_index,
    input  wire logic [SEG_W-1:0]   i_segments,
    input  wire logic               i_dot,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output logic [1:0]              o_kind,
    output logic [DIGIT_W-1:0]      o_line_digit,
    output logic                    o_line_level,
    output logic [SEG_W-1:0]        o_segment_bits,
    output logic                    o_status,
    output logic                    o_last,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready
);

    t_cfg cfg;
    logic count_written;
    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_valid;
    t_cmd q_out;
    logic q_pop;
    logic res_valid;
    t_res res;

    ssd_cfg #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_cfg          (cfg),
        .o_count_written(count_written)
    );

    ssd_front #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_front (
        .i_push       (i_push),
        .i_func       (i_func),
        .i_now_ms     (i_now_ms),
        .i_digit_index(i_digit_index),
        .i_segments   (i_segments),
        .i_dot        (i_dot),
        .i_cfg        (cfg),
        .i_q_full     (q_full),
        .o_full       (o_full),
        .o_q_push     (q_push),
        .o_cmd        (q_in)
    );

    ssd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_out)
    );

    ssd_back #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_count_written(count_written),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_out),
        .o_cmd_pop      (q_pop),
        .i_pop          (i_pop),
        .o_valid        (res_valid),
        .o_res          (res)
    );

    assign o_empty        = !res_valid;
    assign o_kind         = res.kind;
    assign o_line_digit   = res.line_digit;
    assign o_line_level   = res.line_level;
    assign o_segment_bits = res.segment_bits;
    assign o_status       = res.status;
    assign o_last         = res.last;

endmodule

`default_nettype wire

// ===== test/seven_segment_scan_checker.sv =====
module seven_segment_scan_checker
    import ssd_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic               i_full,
    input  wire logic [1:0]         i_func,
    input  wire logic [NOW_W-1:0]   i_now_ms,
    input  wire logic [DIGIT_W-1:0] i_digit_index,
    input  wire logic [SEG_W-1:0]   i_segments,
    input  wire logic               i_dot,
    input  wire logic               i_empty,
    input  wire logic               i_pop,
    input  wire logic [1:0]         i_kind,
    input  wire logic [DIGIT_W-1:0] i_line_digit,
    input  wire logic               i_line_level,
    input  wire logic [SEG_W-1:0]   i_segment_bits,
    input  wire logic               i_status,
    input  wire logic               i_last,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    input  wire logic               pready,
    output int                      o_mismatches,
    output int                      o_awaited
);

    logic [SEG_W-1:0]   digit_patterns [MAX_DIGITS];
    logic [DIGIT_W-1:0] scan_digit;
    logic [NOW_W-1:0]   last_step_ms;
    logic [FRAME_W-1:0] step_period;
    logic [CNT_W-1:0]   digits_used;
    logic               anode_wiring;
    logic [FRAME_W-1:0] frame_ms;
    t_res               awaited_drives [$];
    int                 mismatch_total = 0;

    function automatic t_res make_drive(input logic [1:0] kind, input logic [DIGIT_W-1:0] digit,
                                        input logic level, input logic [SEG_W-1:0] bits,
                                        input logic st, input logic fin);
        t_res r;
        r.kind         = kind;
        r.line_digit   = digit;
        r.line_level   = level;
        r.segment_bits = bits;
        r.status       = st;
        r.last         = fin;
        return r;
    endfunction

    // The digit period never drops below one millisecond.
    task automatic refresh_period();
        step_period = frame_ms / FRAME_W'(digits_used);
        if (step_period == '0) begin
            step_period = FRAME_W'(1);
        end
    endtask

    task automatic reset_display();
        for (int i = 0; i < MAX_DIGITS; i++) begin
            digit_patterns[i] = '0;
        end
        scan_digit   = '0;
        last_step_ms = '0;
        digits_used  = RESET_DIGIT_COUNT;
        anode_wiring = 1'b0;
        frame_ms     = RESET_FRAME_TIME;
        refresh_period();
        awaited_drives.delete();
    endtask

    task automatic apply_register_write(input logic [APB_AW-1:0] addr,
                                        input logic [APB_DW-1:0] data);
        logic [CNT_W-1:0] cnt;
        case (addr[APB_AW-1:2])
            REG_DIGIT_COUNT: begin
                cnt = data[CNT_W-1:0];
                if (cnt == '0) begin
                    cnt = CNT_W'(1);
                end
                if (cnt > MAX_DIGITS) begin
                    cnt = CNT_W'(MAX_DIGITS);
                end
                digits_used = cnt;
                scan_digit  = '0;
                refresh_period();
            end
            REG_COMMON_ANODE: begin
                anode_wiring = data[0];
            end
            REG_FRAME_TIME: begin
                frame_ms = data[FRAME_W-1:0];
                refresh_period();
            end
            default: begin
            end
        endcase
    endtask

    task automatic predict_display_item(input logic [1:0] func, input logic [NOW_W-1:0] now,
                                        input logic [DIGIT_W-1:0] idx,
                                        input logic [SEG_W-1:0] seg, input logic dot);
        logic               off_level;
        logic [NOW_W-1:0]   elapsed;
        logic [DIGIT_W-1:0] d;
        logic [SEG_W-1:0]   bits;
        off_level = ~anode_wiring;
        case (func)
            FUNC_TIME: begin
                // Elapsed time is taken modulo 2^32 so that the counter may wrap.
                elapsed = now - last_step_ms;
                if (elapsed >= NOW_W'(step_period)) begin
                    d = scan_digit;
                    if (d >= digits_used) begin
                        d = '0;
                    end
                    bits = digit_patterns[d];
                    if (anode_wiring) begin
                        bits = ~bits;
                    end
                    awaited_drives.push_back(make_drive(KIND_LINE, d, off_level, '0, 1'b0, 1'b0));
                    awaited_drives.push_back(make_drive(KIND_SEG, '0, 1'b0, bits, 1'b0, 1'b0));
                    awaited_drives.push_back(make_drive(KIND_LINE, d, ~off_level, '0, 1'b0, 1'b1));
                    scan_digit   = DIGIT_W'((32'(d) + 1) % 32'(digits_used));
                    last_step_ms = now;
                end
            end
            FUNC_WRITE: begin
                if (idx >= digits_used) begin
                    awaited_drives.push_back(make_drive(KIND_STATUS, '0, 1'b0, '0,
                                                        STATUS_RANGE, 1'b1));
                end else begin
                    digit_patterns[idx] = (seg & SEG_MASK) | (dot ? DOT_BIT : BLANK_CATH);
                    awaited_drives.push_back(make_drive(KIND_STATUS, '0, 1'b0, '0,
                                                        STATUS_OK, 1'b1));
                end
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < MAX_DIGITS; i++) begin
                    digit_patterns[i] = '0;
                end
                for (int i = 0; i < digits_used; i++) begin
                    awaited_drives.push_back(make_drive(KIND_LINE, DIGIT_W'(i), off_level, '0,
                                                        1'b0, 1'b0));
                end
                awaited_drives.push_back(make_drive(KIND_SEG, '0, 1'b0,
                                                    anode_wiring ? BLANK_ANODE : BLANK_CATH,
                                                    1'b0, 1'b1));
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("checker: %s got %0h want %0h at %0t", what, got, want, $time);
        mismatch_total++;
    endtask

    task automatic check_drive();
        t_res want;
        if (awaited_drives.size() == 0) begin
            report_mismatch("result transfer with nothing awaited, kind", 32'(i_kind), '0);
        end else begin
            want = awaited_drives.pop_front();
            if (i_kind != want.kind)
                report_mismatch("kind", 32'(i_kind), 32'(want.kind));
            if (i_line_digit != want.line_digit)
                report_mismatch("line_digit", 32'(i_line_digit), 32'(want.line_digit));
            if (i_line_level != want.line_level)
                report_mismatch("line_level", 32'(i_line_level), 32'(want.line_level));
            if (i_segment_bits != want.segment_bits)
                report_mismatch("segment_bits", 32'(i_segment_bits), 32'(want.segment_bits));
            if (i_status != want.status)
                report_mismatch("status", 32'(i_status), 32'(want.status));
            if (i_last != want.last)
                report_mismatch("last", 32'(i_last), 32'(want.last));
        end
    endtask

    // A result cannot leave in the same cycle as the item that causes it, so the
    // result transfer is checked before the new item is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_display();
        end else begin
            if (psel && penable && pwrite && pready) begin
                apply_register_write(paddr, pwdata);
            end
            if (i_pop && !i_empty) begin
                check_drive();
            end
            if (i_push && !i_full) begin
                predict_display_item(i_func, i_now_ms, i_digit_index, i_segments, i_dot);
            end
        end
        o_mismatches <= mismatch_total;
        o_awaited    <= awaited_drives.size();
    end

endmodule

// ===== test/tb_seven_segment_scan_driver.sv =====
module tb_seven_segment_scan_driver;
    import ssd_pkg::*;

    localparam logic [1:0] FUNC_IGNORED = 2'd3;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 32;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_push;
    logic               o_full;
    logic [1:0]         i_func;
    logic [NOW_W-1:0]   i_now_ms;
    logic [DIGIT_W-1:0] i_digit_index;
    logic [SEG_W-1:0]   i_segments;
    logic               i_dot;
    logic               o_empty;
    logic               i_pop;
    logic [1:0]         o_kind;
    logic [DIGIT_W-1:0] o_line_digit;
    logic               o_line_level;
    logic [SEG_W-1:0]   o_segment_bits;
    logic               o_status;
    logic               o_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int                 mismatches;
    int                 awaited;
    int                 quiet_cycles = 0;
    bit                 send_gaps    = 1'b1;
    bit                 take_gaps    = 1'b1;
    bit                 hold_results = 1'b0;
    logic [NOW_W-1:0]   clock_ms;
    int                 period_hint;

    seven_segment_scan_driver u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_func         (i_func),
        .i_now_ms       (i_now_ms),
        .i_digit_index  (i_digit_index),
        .i_segments     (i_segments),
        .i_dot          (i_dot),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_kind         (o_kind),
        .o_line_digit   (o_line_digit),
        .o_line_level   (o_line_level),
        .o_segment_bits (o_segment_bits),
        .o_status       (o_status),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    seven_segment_scan_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_full         (o_full),
        .i_func         (i_func),
        .i_now_ms       (i_now_ms),
        .i_digit_index  (i_digit_index),
        .i_segments     (i_segments),
        .i_dot          (i_dot),
        .i_empty        (o_empty),
        .i_pop          (i_pop),
        .i_kind         (o_kind),
        .i_line_digit   (o_line_digit),
        .i_line_level   (o_line_level),
        .i_segment_bits (o_segment_bits),
        .i_status       (o_status),
        .i_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_mismatches   (mismatches),
        .o_awaited      (awaited)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Result side: a fresh wait is drawn for every result, and a long hold-off
    // is taken when the stimulus asks for one.
    initial begin : result_taker
        int gap;
        i_pop <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                i_pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end
            gap = take_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
        end
    end

    task automatic offer_item(input logic [1:0] func, input logic [NOW_W-1:0] now,
                              input logic [DIGIT_W-1:0] idx, input logic [SEG_W-1:0] seg,
                              input logic dot);
        int gap;
        gap = send_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push        <= 1'b1;
        i_func        <= func;
        i_now_ms      <= now;
        i_digit_index <= idx;
        i_segments    <= seg;
        i_dot         <= dot;
        do @(posedge i_clk); while (o_full);
    endtask

    // Waits for every awaited result, then long enough for a trailing time
    // item that causes nothing to leave the block.
    task automatic drain_results();
        i_push <= 1'b0;
        do @(posedge i_clk); while (awaited != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_display(input logic [CNT_W-1:0] cnt, input logic anode,
                               input logic [FRAME_W-1:0] frame);
        int used;
        write_register(REG_DIGIT_COUNT, APB_DW'(cnt));
        write_register(REG_COMMON_ANODE, APB_DW'(anode));
        write_register(REG_FRAME_TIME, APB_DW'(frame));
        used = (cnt == 0) ? 1 : ((cnt > DEFAULT_MAX_DIGITS) ? DEFAULT_MAX_DIGITS : int'(cnt));
        period_hint = int'(frame) / used;
        if (period_hint == 0) begin
            period_hint = 1;
        end
    endtask

    task automatic run_directed();
        // Reset settings: four digits, common cathode, a four millisecond step.
        offer_item(FUNC_WRITE, 32'h0, 3'd0, 8'hFF, 1'b1);
        offer_item(FUNC_WRITE, 32'h0, 3'd3, 8'h80, 1'b0);
        offer_item(FUNC_WRITE, 32'h0, 3'd4, 8'h55, 1'b1);
        offer_item(FUNC_WRITE, 32'h0, 3'd7, 8'hFF, 1'b1);
        offer_item(FUNC_IGNORED, 32'hFFFF_FFFF, 3'd7, 8'hFF, 1'b1);
        offer_item(FUNC_TIME, 32'd3, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_TIME, 32'd4, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_TIME, 32'd5, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_TIME, 32'd8, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_TIME, 32'hFFFF_FFFF, 3'd0, 8'h00, 1'b0);
        // Across the wrap of the millisecond counter.
        offer_item(FUNC_TIME, 32'd2, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_TIME, 32'd3, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_CLEAR, 32'h0, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_TIME, 32'h1000, 3'd0, 8'h00, 1'b0);
        drain_results();
        // A zero digit count becomes one and a zero frame gives a one millisecond step.
        set_display(4'd0, 1'b1, 16'd0);
        offer_item(FUNC_WRITE, 32'h0, 3'd0, 8'h7F, 1'b0);
        offer_item(FUNC_WRITE, 32'h0, 3'd1, 8'h7F, 1'b1);
        offer_item(FUNC_TIME, 32'h1001, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_TIME, 32'h1001, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_TIME, 32'h1002, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_CLEAR, 32'h0, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_TIME, 32'h1003, 3'd0, 8'h00, 1'b0);
        drain_results();
        // An oversized digit count is held at the maximum.
        set_display(4'd15, 1'b0, 16'hFFFF);
        offer_item(FUNC_WRITE, 32'h0, 3'd7, 8'h01, 1'b1);
        offer_item(FUNC_TIME, 32'h1003 + 32'd8190, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_TIME, 32'h1003 + 32'd8191, 3'd0, 8'h00, 1'b0);
        offer_item(FUNC_CLEAR, 32'h0, 3'd0, 8'h00, 1'b0);
        clock_ms = 32'h1003 + 32'd8191;
    endtask

    task automatic offer_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            if ($urandom_range(0, 15) == 0) begin
                clock_ms = NOW_W'($urandom);
            end else begin
                clock_ms = clock_ms + NOW_W'($urandom_range(0, 2 * period_hint));
            end
            offer_item(FUNC_TIME, clock_ms, DIGIT_W'($urandom), SEG_W'($urandom),
                       1'($urandom));
        end else if (pick < 88) begin
            offer_item(FUNC_WRITE, NOW_W'($urandom), DIGIT_W'($urandom_range(0, 7)),
                       SEG_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (pick < 95) begin
            offer_item(FUNC_CLEAR, NOW_W'($urandom), DIGIT_W'($urandom), SEG_W'($urandom),
                       1'($urandom));
        end else begin
            offer_item(FUNC_IGNORED, NOW_W'($urandom), DIGIT_W'($urandom), SEG_W'($urandom),
                       1'($urandom));
        end
    endtask

    task automatic run_phase(input int phase);
        logic [CNT_W-1:0]   cnt;
        logic               anode;
        logic [FRAME_W-1:0] frame;
        drain_results();
        case (phase)
            0: begin cnt = 4'd8; anode = 1'b1; frame = 16'd8;    end
            1: begin cnt = 4'd1; anode = 1'b0; frame = 16'hFFFF; end
            2: begin cnt = 4'd5; anode = 1'b1; frame = 16'd1;    end
            default: begin
                cnt   = CNT_W'($urandom_range(0, 15));
                anode = 1'($urandom_range(0, 1));
                frame = ($urandom_range(0, 3) == 0) ? FRAME_W'($urandom)
                                                    : FRAME_W'($urandom_range(0, 48));
            end
        endcase
        set_display(cnt, anode, frame);
        send_gaps = (phase % 3) != 1;
        take_gaps = (phase % 3) != 2;
        // Here the result side stops for a long stretch while items keep coming,
        // so the block fills and holds off further input transfers.
        if (phase == 3) begin
            send_gaps    = 1'b0;
            hold_results = 1'b1;
        end
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            offer_random_item();
        end
    endtask

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_push        <= 1'b0;
        i_func        <= FUNC_TIME;
        i_now_ms      <= '0;
        i_digit_index <= '0;
        i_segments    <= '0;
        i_dot         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        period_hint   = int'(RESET_PERIOD);
        clock_ms      = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int phase = 0; phase < PHASES; phase++) begin
            run_phase(phase);
        end
        drain_results();
        if (mismatches == 0 && awaited == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== seven_segment_scan_driver.f =====
sv/ssd_pkg.sv
sv/ssd_cfg.sv
sv/ssd_front.sv
sv/ssd_fifo.sv
sv/ssd_back.sv
sv/seven_segment_scan_driver.sv
test/seven_segment_scan_checker.sv
test/tb_seven_segment_scan_driver.sv
